### rtl/core/fpbq_pkg.sv
// Shared types and constants for the fixed-point biquad filter.
`default_nettype none

package fpbq_pkg;

  // Data widths of samples, coefficients and the wrapping accumulator.
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int ACC_W     = 32;
  localparam int ACC_SHIFT = 2;

  // Output sample is taken from this bit of the accumulator upward.
  localparam int OUT_LSB   = ACC_W - ACC_SHIFT - SAMPLE_W;

  // Configuration register index width and register map.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X0 = 3'd0,
    REG_COEF_X1 = 3'd1,
    REG_COEF_X2 = 3'd2,
    REG_COEF_Y1 = 3'd3,
    REG_COEF_Y2 = 3'd4
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Full coefficient set handed from the register bank to the datapath.
  typedef struct packed {
    coef_t x0;
    coef_t x1;
    coef_t x2;
    coef_t y1;
    coef_t y2;
  } coef_set_t;

endpackage

`default_nettype wire

### rtl/core/fpbq_coef_regs.sv
// Coefficient register bank written through the configuration port.
`default_nettype none

module fpbq_coef_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [fpbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpbq_pkg::COEF_W-1:0]  cfg_wdata,
  output fpbq_pkg::coef_set_t               coefs
);
  import fpbq_pkg::*;

  coef_set_t coefs_r;
  coef_set_t coefs_nxt;

  // Decode the register index; indexes past the map are dropped.
  always_comb begin
    coefs_nxt = coefs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COEF_X0: coefs_nxt.x0 = coef_t'(cfg_wdata);
        REG_COEF_X1: coefs_nxt.x1 = coef_t'(cfg_wdata);
        REG_COEF_X2: coefs_nxt.x2 = coef_t'(cfg_wdata);
        REG_COEF_Y1: coefs_nxt.y1 = coef_t'(cfg_wdata);
        REG_COEF_Y2: coefs_nxt.y2 = coef_t'(cfg_wdata);
        default:     coefs_nxt = coefs_r;
      endcase
    end
  end

  // All coefficients clear to zero at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r <= '0;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  assign coefs = coefs_r;

endmodule

`default_nettype wire

### rtl/core/fpbq_mac.sv
// Biquad multiply-accumulate datapath with input and output history.
`default_nettype none

module fpbq_mac (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire fpbq_pkg::sample_t   x,
  input  wire fpbq_pkg::coef_set_t coefs,
  output fpbq_pkg::sample_t        y
);
  import fpbq_pkg::*;

  sample_t prev_in1_r;
  sample_t prev_in2_r;
  sample_t prev_out1_r;
  sample_t prev_out2_r;

  acc_t p_x0;
  acc_t p_x1;
  acc_t p_x2;
  acc_t p_y1;
  acc_t p_y2;
  acc_t acc;
  acc_t acc_shifted;

  // Five signed 16x16 products; each fits in 32 bits exactly.
  assign p_x0 = acc_t'(x)           * acc_t'(coefs.x0);
  assign p_x1 = acc_t'(prev_in1_r)  * acc_t'(coefs.x1);
  assign p_x2 = acc_t'(prev_in2_r)  * acc_t'(coefs.x2);
  assign p_y1 = acc_t'(prev_out1_r) * acc_t'(coefs.y1);
  assign p_y2 = acc_t'(prev_out2_r) * acc_t'(coefs.y2);

  // Feedforward minus feedback, wrapping modulo 2^32, then the Q14 scale.
  assign acc         = (p_x0 + p_x1) + (p_x2 - p_y1) - p_y2;
  assign acc_shifted = acc <<< ACC_SHIFT;
  assign y           = sample_t'(acc_shifted[ACC_W-1 -: SAMPLE_W]);

  // The sample histories shift by one each time a word completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in1_r  <= '0;
      prev_in2_r  <= '0;
      prev_out1_r <= '0;
      prev_out2_r <= '0;
    end else if (advance) begin
      prev_in2_r  <= prev_in1_r;
      prev_in1_r  <= x;
      prev_out2_r <= prev_out1_r;
      prev_out1_r <= y;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fixed_point_biquad_filter_top.sv
// Top level of the fixed-point direct-form-I biquad filter.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+--------------------------
//  in       | input     | in_valid / in_stall  | in_sample_in  (s16)
//  out      | output    | out_valid / out_stall| out_sample_out (s16)
//  cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// One word per cycle is sustained while the output is not stalled; a word taken
// waits in the input register and its result then goes to the output register.
// The input register holds one word while the output register waits, so a
// new word is taken while a finished result is still stalled.
// The history feedback path through the multiplies and the adder tree is
// combinational. Synchronous reset clears coefficients, history, valids.
`default_nettype none

module fixed_point_biquad_filter_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire fpbq_pkg::sample_t              in_sample_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output fpbq_pkg::sample_t                   out_sample_out,
  input  wire logic                           cfg_we,
  input  wire logic [fpbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpbq_pkg::COEF_W-1:0]    cfg_wdata
);
  import fpbq_pkg::*;

  coef_set_t coefs;
  sample_t   y;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  sample_t s1_x_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  sample_t out_sample_r;

  logic in_accept;
  logic out_free;
  logic s1_fire;

  // Coefficient storage.
  fpbq_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coefs     (coefs)
  );

  // Filter arithmetic; history advances when the input word moves on.
  fpbq_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_fire),
    .x       (s1_x_r),
    .coefs   (coefs),
    .y       (y)
  );

  // Handshake control between the input register and the output register.
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r <= in_sample_in;
    end
    if (s1_fire) begin
      out_sample_r <= y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // The input side only stalls while a word is held in the input register.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // A word leaving the input register always lands in the output register.
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("output register empty after a transfer");

  // A held input word keeps its value until it moves on.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_x_r)))
    else $error("held input word lost or changed");

  // Reset leaves both stages empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("stage valid after reset");

endmodule

`default_nettype wire
